// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define TSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define TSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tsd_pkg.sv =====
// Types, constants and helper functions of the thermometer scratchpad decoder.
package tsd_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LENGTH = 2'd1,
    ST_CRC    = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] scratch_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] celsius_x100;
    logic signed [15:0] fahrenheit_x100;
  } out_t;

  // Scratchpad byte positions
  localparam logic [3:0] IDX_TEMP_LO = 4'd0;
  localparam logic [3:0] IDX_TEMP_HI = 4'd1;
  localparam logic [3:0] IDX_CONFIG  = 4'd4;
  localparam logic [3:0] IDX_CRC     = 4'd8;
  localparam logic [3:0] COUNT_MAX   = 4'd15;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Widths of the conversion datapath
  localparam int MAG_W    = 17;
  localparam int M25_W    = 22;
  localparam int SCALED_W = 18;
  localparam int T9_W     = 21;
  localparam int PROD_W   = 42;
  localparam int QUOT_W   = 19;
  localparam int FSUM_W   = 20;

  // floor(x / 5) = (x * DIV5_RECIP) >> DIV5_SHIFT, exact for x < 2**22
  localparam logic [T9_W-1:0] DIV5_RECIP = 21'd1677722;
  localparam int              DIV5_SHIFT = 23;

  localparam logic [SCALED_W-1:0] CEL_POS_LIM = 18'd32767;
  localparam logic [SCALED_W-1:0] CEL_NEG_LIM = 18'd32768;
  localparam logic [FSUM_W-1:0]   FAH_OFFSET  = 20'd3200;
  localparam logic [FSUM_W-1:0]   FAH_POS_LIM = 20'd32767;
  localparam logic [QUOT_W-1:0]   FAH_NEG_LIM = 19'd35968;

  localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S16_MIN = 16'sh8000;

  // One byte of the reflected 1-Wire CRC-8
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // x * 25 as shift-add
  function automatic logic [M25_W-1:0] mul25(input logic [MAG_W-1:0] x);
    return {1'b0, x, 4'b0} + {2'b0, x, 3'b0} + {5'b0, x};
  endfunction

endpackage

// ===== rtl/core/thermometer_scratchpad_decoder_top.sv =====
// Top level of the thermometer scratchpad decoder.
//
// Usage
//   Input channel (in_valid / in_stall / in_data): one scratchpad byte per
//   transaction, byte 0 first, with last_byte set on the final byte of the
//   response. A byte may be offered on every clock.
//   Output channel (out_valid / out_stall / out_data): one transaction per
//   byte marked last, carrying the status and, when the status is ok, the
//   temperature in hundredths of a degree C and F (zero otherwise).
// Throughput and pipeline
//   One byte per cycle is accepted unless a result is held on a stalled
//   output. The result of a last byte passes through the three-register
//   conversion pipeline: magnitude scaling, the x9/5 multiply by a
//   reciprocal, then offset and saturation, before it shows on out_valid.
// Reset
//   Synchronous, active low: the byte count, CRC and stored bytes clear and
//   the pipeline empties.
// Stall
//   While a result is held on the output with out_stall high, the whole
//   pipeline freezes and in_stall is raised, so no byte is taken.
module thermometer_scratchpad_decoder_top
  import tsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // Response tracking state
  logic [3:0] count_r, count_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] lo_r, lo_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic [7:0] cfg_r, cfg_nxt;

  // Pipeline registers
  logic                s1_valid_r, s1_valid_nxt;
  status_t             s1_status_r, s1_status_nxt;
  logic                s1_neg_r;
  logic [SCALED_W-1:0] s1_scaled_r, s1_scaled_nxt;
  logic [MAG_W-1:0]    mag;
  logic                neg;

  logic                s2_valid_r;
  status_t             s2_status_r;
  logic                s2_neg_r;
  logic [SCALED_W-1:0] s2_scaled_r;
  logic [QUOT_W-1:0]   s2_quot_r, s2_quot_nxt;

  logic out_valid_r;
  out_t out_r, out_nxt;

  logic        adv;
  logic        accept;
  logic [7:0]  crc_step;
  logic [15:0] raw;

  // Whole pipeline moves unless a result is held on the output
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign crc_step = crc8_step(crc_r, in_data.scratch_byte);

  // Byte bookkeeping
  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    cfg_nxt   = cfg_r;
    if (accept) begin
      if (count_r < IDX_CRC) begin
        crc_nxt = crc_step;
        if (count_r == IDX_TEMP_LO) begin
          lo_nxt = in_data.scratch_byte;
        end else if (count_r == IDX_TEMP_HI) begin
          hi_nxt = in_data.scratch_byte;
        end else if (count_r == IDX_CONFIG) begin
          cfg_nxt = in_data.scratch_byte;
        end
      end
      if (count_r != COUNT_MAX) begin
        count_nxt = count_r + 4'd1;
      end
      // End of response: restart count and CRC
      if (in_data.last_byte) begin
        count_nxt = '0;
        crc_nxt   = '0;
      end
    end
  end

  // Stage 1: status and scaled magnitude. The stored bytes are final by the
  // ninth byte, so they are read from the registers directly.
  assign raw = {hi_r, lo_r};
  assign neg = raw[15];
  assign mag = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};

  always_comb begin
    logic [M25_W-1:0] p;
    p = '0;
    case (cfg_r[6:5])
      2'd0: begin
        p             = mul25({3'b0, mag[MAG_W-1:3]});
        s1_scaled_nxt = {p[SCALED_W-2:0], 1'b0};
      end
      2'd1: begin
        p             = mul25({2'b0, mag[MAG_W-1:2]});
        s1_scaled_nxt = p[SCALED_W-1:0];
      end
      2'd2: begin
        p             = mul25({1'b0, mag[MAG_W-1:1]});
        s1_scaled_nxt = p[SCALED_W:1];
      end
      default: begin
        p             = mul25(mag);
        s1_scaled_nxt = p[SCALED_W+1:2];
      end
    endcase
  end

  always_comb begin
    s1_valid_nxt = accept && in_data.last_byte;
    if (count_r != IDX_CRC) begin
      s1_status_nxt = ST_LENGTH;
    end else if (in_data.scratch_byte != crc_r) begin
      s1_status_nxt = ST_CRC;
    end else begin
      s1_status_nxt = ST_OK;
    end
  end

  // Stage 2: floor(scaled * 9 / 5) through the reciprocal of five
  always_comb begin
    logic [T9_W-1:0]   t9;
    logic [PROD_W-1:0] prod;
    t9          = {s1_scaled_r, 3'b0} + {3'b0, s1_scaled_r};
    prod        = {{(PROD_W-T9_W){1'b0}}, t9} * {{(PROD_W-T9_W){1'b0}}, DIV5_RECIP};
    s2_quot_nxt = prod[DIV5_SHIFT+QUOT_W-1:DIV5_SHIFT];
  end

  // Stage 3: sign, offset and saturation
  always_comb begin
    logic [FSUM_W-1:0] fsum;
    logic [FSUM_W-1:0] fdiff;
    fsum  = {1'b0, s2_quot_r} + FAH_OFFSET;
    fdiff = FAH_OFFSET - {1'b0, s2_quot_r};
    out_nxt.status          = s2_status_r;
    out_nxt.celsius_x100    = '0;
    out_nxt.fahrenheit_x100 = '0;
    if (s2_status_r == ST_OK) begin
      if (s2_neg_r) begin
        out_nxt.celsius_x100 = (s2_scaled_r > CEL_NEG_LIM) ? S16_MIN :
                               16'(18'd0 - s2_scaled_r);
        out_nxt.fahrenheit_x100 = (s2_quot_r > FAH_NEG_LIM) ? S16_MIN : fdiff[15:0];
      end else begin
        out_nxt.celsius_x100 = (s2_scaled_r > CEL_POS_LIM) ? S16_MAX : s2_scaled_r[15:0];
        out_nxt.fahrenheit_x100 = (fsum > FAH_POS_LIM) ? S16_MAX : fsum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      crc_r       <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      cfg_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      cfg_r   <= cfg_nxt;
      if (adv) begin
        s1_valid_r  <= s1_valid_nxt;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_status_r <= s1_status_nxt;
      s1_neg_r    <= neg;
      s1_scaled_r <= s1_scaled_nxt;
      s2_status_r <= s1_status_r;
      s2_neg_r    <= s1_neg_r;
      s2_scaled_r <= s1_scaled_r;
      s2_quot_r   <= s2_quot_nxt;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/tsd_port_checker.sv =====
// Port-level assertions for the thermometer scratchpad decoder, with bind.
`include "assert_macros.svh"

module tsd_port_checker
  import tsd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  logic ok_res;
  assign ok_res = out_valid && (out_data.status == ST_OK);

  `TSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `TSD_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && (out_data.status != ST_OK), (out_data.celsius_x100 == 16'sd0) && (out_data.fahrenheit_x100 == 16'sd0), "error result carries a value")
  `TSD_ASSERT_IMPL(a_pos_fah, clk, rst_n, ok_res && (out_data.celsius_x100 > 16'sd0), out_data.fahrenheit_x100 > 16'sd3200, "positive C with F not above freezing")
  `TSD_ASSERT_IMPL(a_neg_fah, clk, rst_n, ok_res && (out_data.celsius_x100 < 16'sd0), out_data.fahrenheit_x100 < 16'sd3200, "negative C with F not below freezing")
  `TSD_ASSERT_IMPL(a_zero_fah, clk, rst_n, ok_res && (out_data.celsius_x100 == 16'sd0), out_data.fahrenheit_x100 == 16'sd3200, "zero C not mapped to freezing")

endmodule

bind thermometer_scratchpad_decoder_top tsd_port_checker u_tsd_port_checker (.*);
